// File: sv/e2r_pkg.sv
`default_nettype none
package e2r_pkg;
    localparam int unsigned CordicSteps = 30;
    localparam int unsigned PhaseBits   = 32;
    localparam int unsigned VecBits     = 34;
    localparam logic signed [VecBits-1:0] CordicOneK = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } t_in;

    typedef struct packed {
        logic signed [15:0] col0_x;
        logic signed [15:0] col0_y;
        logic signed [15:0] col0_z;
        logic signed [15:0] col1_x;
        logic signed [15:0] col1_y;
        logic signed [15:0] col1_z;
        logic signed [15:0] col2_x;
        logic signed [15:0] col2_y;
        logic signed [15:0] col2_z;
    } t_out;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [PhaseBits:0] atan_turn(input logic [4:0] i);
        logic signed [PhaseBits:0] t;
        begin
            unique case (i)
                5'd0:  t = 33'sd536870912;
                5'd1:  t = 33'sd316933406;
                5'd2:  t = 33'sd167458907;
                5'd3:  t = 33'sd85004756;
                5'd4:  t = 33'sd42667331;
                5'd5:  t = 33'sd21354465;
                5'd6:  t = 33'sd10679838;
                5'd7:  t = 33'sd5340245;
                5'd8:  t = 33'sd2670163;
                5'd9:  t = 33'sd1335087;
                5'd10: t = 33'sd667544;
                5'd11: t = 33'sd333772;
                5'd12: t = 33'sd166886;
                5'd13: t = 33'sd83443;
                5'd14: t = 33'sd41722;
                5'd15: t = 33'sd20861;
                5'd16: t = 33'sd10430;
                5'd17: t = 33'sd5215;
                5'd18: t = 33'sd2608;
                5'd19: t = 33'sd1304;
                5'd20: t = 33'sd652;
                5'd21: t = 33'sd326;
                5'd22: t = 33'sd163;
                5'd23: t = 33'sd81;
                5'd24: t = 33'sd41;
                5'd25: t = 33'sd20;
                5'd26: t = 33'sd10;
                5'd27: t = 33'sd5;
                5'd28: t = 33'sd3;
                5'd29: t = 33'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction
endpackage
`default_nettype wire

// File: sv/e2r_cordic.sv
`default_nettype none
// Pipelined sin/cos: one register stage per CORDIC iteration.
module e2r_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_valid,
    input  wire signed [15:0]                         i_angle,
    output logic                                      o_valid,
    output logic signed [e2r_pkg::VecBits-1:0]        o_cos,
    output logic signed [e2r_pkg::VecBits-1:0]        o_sin
);
    localparam int N  = e2r_pkg::CordicSteps;
    localparam int VB = e2r_pkg::VecBits;
    localparam int PB = e2r_pkg::PhaseBits;

    logic                 r_v [0:N];
    logic signed [VB-1:0] r_x [0:N];
    logic signed [VB-1:0] r_y [0:N];
    logic signed [PB:0]   r_z [0:N];
    logic [1:0]           r_q [0:N];

    logic [PB-1:0] phase, resid;
    logic [1:0]    quad;
    logic [31:0]   ext;

    always_comb begin
        ext   = 32'($signed(i_angle));
        phase = ext[PB-1:0] << (PB - ANGLE_BITS);
        quad  = 2'((phase + 32'h2000_0000) >> 30);
        resid = phase - {quad, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_x[0] <= e2r_pkg::CordicOneK;
        r_y[0] <= '0;
        r_z[0] <= (PB+1)'($signed(resid));
        r_q[0] <= quad;
    end

    for (genvar i = 0; i < N; i++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            if (!r_z[i][PB]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - e2r_pkg::atan_turn(5'(i));
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + e2r_pkg::atan_turn(5'(i));
            end
            r_q[i+1] <= r_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[N];
        end
        unique case (r_q[N])
            2'd0: begin o_cos <= r_x[N];  o_sin <= r_y[N];  end
            2'd1: begin o_cos <= -r_y[N]; o_sin <= r_x[N];  end
            2'd2: begin o_cos <= -r_x[N]; o_sin <= -r_y[N]; end
            default: begin o_cos <= r_y[N]; o_sin <= -r_x[N]; end
        endcase
    end
endmodule
`default_nettype wire

// File: sv/e2r_matrix.sv
`default_nettype none
// Product pipeline: pair products, triple products, sums, output rounding.
module e2r_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    input  wire signed [e2r_pkg::VecBits-1:0]  i_cy,
    input  wire signed [e2r_pkg::VecBits-1:0]  i_sy,
    input  wire signed [e2r_pkg::VecBits-1:0]  i_cp,
    input  wire signed [e2r_pkg::VecBits-1:0]  i_sp,
    input  wire signed [e2r_pkg::VecBits-1:0]  i_cr,
    input  wire signed [e2r_pkg::VecBits-1:0]  i_sr,
    output logic                               o_valid,
    output e2r_pkg::t_out                      o_res
);
    localparam int VB = e2r_pkg::VecBits;
    localparam int PW = 2 * VB;
    localparam int SH = 30 - FRAC_BITS;
    localparam int AW = VB + 2;
    localparam logic signed [PW-1:0] HalfQ = PW'(64'sd1 <<< 29);

    function automatic logic signed [VB-1:0] rnd30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        begin
            t = (p + HalfQ) >>> 30;
            return t[VB-1:0];
        end
    endfunction

    function automatic logic [15:0] to_out(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r, lim;
        begin
            lim = AW'(64'sd1 <<< FRAC_BITS);
            if (SH > 0) r = (v + AW'(64'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
            else        r = v;
            if (r > lim)       r = lim;
            else if (r < -lim) r = -lim;
            return r[15:0];
        end
    endfunction

    // stage 1: pair products
    logic r_v1;
    logic signed [VB-1:0] r_crsp, r_srsp, r_crcp, r_srcp, r_srcy, r_srsy;
    logic signed [VB-1:0] r_crcy, r_crsy, r_cpsy, r_cpcy, r_sp1, r_sy1, r_cy1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= i_valid;
        r_crsp <= rnd30(PW'(i_cr) * PW'(i_sp));
        r_srsp <= rnd30(PW'(i_sr) * PW'(i_sp));
        r_crcp <= rnd30(PW'(i_cr) * PW'(i_cp));
        r_srcp <= rnd30(PW'(i_sr) * PW'(i_cp));
        r_srcy <= rnd30(PW'(i_sr) * PW'(i_cy));
        r_srsy <= rnd30(PW'(i_sr) * PW'(i_sy));
        r_crcy <= rnd30(PW'(i_cr) * PW'(i_cy));
        r_crsy <= rnd30(PW'(i_cr) * PW'(i_sy));
        r_cpsy <= rnd30(PW'(i_cp) * PW'(i_sy));
        r_cpcy <= rnd30(PW'(i_cp) * PW'(i_cy));
        r_sp1  <= i_sp;
        r_sy1  <= i_sy;
        r_cy1  <= i_cy;
    end

    // stage 2: triple products
    logic r_v2;
    logic signed [VB-1:0] r_a, r_b, r_c, r_d;
    logic signed [VB-1:0] r_crcp2, r_srcp2, r_srcy2, r_srsy2, r_crcy2, r_crsy2;
    logic signed [VB-1:0] r_cpsy2, r_cpcy2, r_sp2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_a <= rnd30(PW'(r_crsp) * PW'(r_sy1));
        r_b <= rnd30(PW'(r_crsp) * PW'(r_cy1));
        r_c <= rnd30(PW'(r_srsp) * PW'(r_sy1));
        r_d <= rnd30(PW'(r_srsp) * PW'(r_cy1));
        r_crcp2 <= r_crcp; r_srcp2 <= r_srcp; r_srcy2 <= r_srcy;
        r_srsy2 <= r_srsy; r_crcy2 <= r_crcy; r_crsy2 <= r_crsy;
        r_cpsy2 <= r_cpsy; r_cpcy2 <= r_cpcy; r_sp2 <= r_sp1;
    end

    // stage 3: sums
    logic r_v3;
    logic signed [AW-1:0] r_e [0:8];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_e[0] <= AW'(r_crcp2);
        r_e[1] <= AW'(r_a) - AW'(r_srcy2);
        r_e[2] <= AW'(r_srsy2) + AW'(r_b);
        r_e[3] <= AW'(r_srcp2);
        r_e[4] <= AW'(r_crcy2) + AW'(r_c);
        r_e[5] <= AW'(r_d) - AW'(r_crsy2);
        r_e[6] <= -AW'(r_sp2);
        r_e[7] <= AW'(r_cpsy2);
        r_e[8] <= AW'(r_cpcy2);
    end

    // stage 4: rounding and saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_v3;
        o_res.col0_x <= to_out(r_e[0]);
        o_res.col0_y <= to_out(r_e[1]);
        o_res.col0_z <= to_out(r_e[2]);
        o_res.col1_x <= to_out(r_e[3]);
        o_res.col1_y <= to_out(r_e[4]);
        o_res.col1_z <= to_out(r_e[5]);
        o_res.col2_x <= to_out(r_e[6]);
        o_res.col2_y <= to_out(r_e[7]);
        o_res.col2_z <= to_out(r_e[8]);
    end
endmodule
`default_nettype wire

// File: sv/euler_to_rotation_matrix.sv
`default_nettype none
// Pipeline from the start transfer to o_done: 31-stage CORDIC plus
//   output register, then four product/sum/round stages.
// Throughput: one item per cycle; busy is never raised, the pipeline is free-running.
// Reset: synchronous, active low; clears only the valid bits in flight.
// The receiver cannot stall: each result shows for one cycle with o_done high.
module euler_to_rotation_matrix #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire e2r_pkg::t_in   i_data,
    output logic                o_done,
    output e2r_pkg::t_out       o_data
);
    localparam int VB = e2r_pkg::VecBits;

    logic                 acc;
    logic                 v_y, v_p, v_r;
    logic signed [VB-1:0] cy, sy, cp, sp, cr, sr;

    // a fully pipelined datapath never needs to refuse a transfer
    assign busy = 1'b0;
    assign acc  = start & ~busy;

    // three identical sin/cos pipes in lockstep
    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .i_clk, .i_rst_n, .i_valid(acc), .i_angle(i_data.yaw),
        .o_valid(v_y), .o_cos(cy), .o_sin(sy));
    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .i_clk, .i_rst_n, .i_valid(acc), .i_angle(i_data.pitch),
        .o_valid(v_p), .o_cos(cp), .o_sin(sp));
    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .i_clk, .i_rst_n, .i_valid(acc), .i_angle(i_data.roll),
        .o_valid(v_r), .o_cos(cr), .o_sin(sr));

    e2r_matrix #(.FRAC_BITS(FRAC_BITS)) u_mat (
        .i_clk, .i_rst_n, .i_valid(v_y & v_p & v_r),
        .i_cy(cy), .i_sy(sy), .i_cp(cp), .i_sp(sp), .i_cr(cr), .i_sr(sr),
        .o_valid(o_done), .o_res(o_data));
endmodule
`default_nettype wire

// File: sv/e2r_checker.sv
`default_nettype none
module e2r_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           start,
    input wire           busy,
    input wire           o_done
);
    a_no_busy: assert property (@(posedge i_clk) busy == 1'b0)
        else $error("busy raised");
    a_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done) else $error("done right after reset");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##36 (o_done || !$past(i_rst_n, 1)))
        else $error("result missing");
endmodule

bind euler_to_rotation_matrix e2r_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done));
`default_nettype wire

// File: tb/euler_to_rotation_matrix_check.sv
module euler_to_rotation_matrix_check #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire           i_busy,
    input  e2r_pkg::t_in  i_data,
    input  wire           i_done,
    input  e2r_pkg::t_out i_res,
    output int            o_errors,
    output int            o_pending
);
    e2r_pkg::t_out matrix_q[$];

    localparam longint AtanTab [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1};

    // Rotation-mode CORDIC with quadrant folding; Q30 cosine and sine.
    function automatic void trig(input logic [15:0] ang, output longint cs,
                                 output longint sn);
        logic [31:0] a, ph, ru;
        logic [1:0] q;
        longint x, y, z, dx, dy;
        a  = 32'(signed'(ang)) & ((32'd1 << ANGLE_BITS) - 1);
        ph = a << (32 - ANGLE_BITS);
        q  = 2'((ph + 32'h2000_0000) >> 30);
        ru = ph - (32'(q) << 30);
        z  = longint'(signed'(ru));
        x  = 652032874;
        y  = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= AtanTab[i];
            end else begin
                x += dx; y -= dy; z += AtanTab[i];
            end
        end
        case (q)
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic logic [15:0] q30_to_out(longint v);
        longint lim;
        int sh;
        sh  = 30 - FRAC_BITS;
        lim = longint'(1) << FRAC_BITS;
        if (sh > 0) v = (v + (longint'(1) << (sh - 1))) >>> sh;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[15:0];
    endfunction

    function automatic e2r_pkg::t_out rot_matrix(e2r_pkg::t_in d);
        longint cy, sy, cp, sp, cr, sr, crsp, srsp;
        e2r_pkg::t_out m;
        trig(d.yaw, cy, sy);
        trig(d.pitch, cp, sp);
        trig(d.roll, cr, sr);
        crsp = qmul(cr, sp);
        srsp = qmul(sr, sp);
        m.col0_x = q30_to_out(qmul(cr, cp));
        m.col0_y = q30_to_out(-qmul(sr, cy) + qmul(crsp, sy));
        m.col0_z = q30_to_out(qmul(sr, sy) + qmul(crsp, cy));
        m.col1_x = q30_to_out(qmul(sr, cp));
        m.col1_y = q30_to_out(qmul(cr, cy) + qmul(srsp, sy));
        m.col1_z = q30_to_out(-qmul(cr, sy) + qmul(srsp, cy));
        m.col2_x = q30_to_out(-sp);
        m.col2_y = q30_to_out(qmul(cp, sy));
        m.col2_z = q30_to_out(qmul(cp, cy));
        return m;
    endfunction

    initial o_errors = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        e2r_pkg::t_out want;
        if (i_rst_n && i_start && !i_busy)
            matrix_q.push_back(rot_matrix(i_data));
        if (i_rst_n && i_done) begin
            if (matrix_q.size() == 0) begin
                o_errors <= o_errors + 1;
                if (o_errors < 10) $display("unexpected result %h", i_res);
            end else begin
                want = matrix_q.pop_front();
                if (want !== i_res) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("mismatch: expected %h actual %h", want, i_res);
                end
            end
        end
        o_pending <= matrix_q.size();
    end
endmodule

// File: tb/euler_to_rotation_matrix_test.sv
module euler_to_rotation_matrix_test;
    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    e2r_pkg::t_in   in_data = '0;
    logic           done;
    e2r_pkg::t_out  res;
    int             errors, pending;

    // Corner angles: zero, the quadrant edges and the field extremes.
    localparam logic [15:0] Corners [10] = '{
        16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
        16'h2000, 16'hE000, 16'h0001, 16'hFFFF, 16'h1FFF};

    initial forever #1 clk = ~clk;

    euler_to_rotation_matrix u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_data(in_data), .o_done(done), .o_data(res));

    euler_to_rotation_matrix_check u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_data(in_data), .i_done(done), .i_res(res),
        .o_errors(errors), .o_pending(pending));

    // One transfer: optional gap, then hold start until accepted.
    task automatic send(input e2r_pkg::t_in d);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 2) == 0) gap = 0;  // back-to-back stretches
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        in_data <= d;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial begin
        e2r_pkg::t_in d;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: all-same corners, then per-axis variety
        for (int i = 0; i < 10; i++) begin
            d.yaw = Corners[i]; d.pitch = Corners[i]; d.roll = Corners[i];
            send(d);
        end
        for (int i = 0; i < 10; i++) begin
            d.yaw = Corners[i]; d.pitch = Corners[(i + 3) % 10];
            d.roll = Corners[(i + 7) % 10];
            send(d);
        end
        // gimbal lock near pitch of a quarter turn gives sums above one
        d = '{16'h1234, 16'h4000, 16'h5678}; send(d);
        d = '{16'h8000, 16'hC000, 16'h7FFF}; send(d);
        for (int n = 0; n < 450; n++) begin
            d.yaw = 16'($urandom); d.pitch = 16'($urandom); d.roll = 16'($urandom);
            if ($urandom_range(0, 4) == 0) d.pitch = Corners[$urandom_range(0, 9)];
            send(d);
        end
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// File: euler_to_rotation_matrix.f
sv/e2r_pkg.sv
sv/e2r_cordic.sv
sv/e2r_matrix.sv
sv/euler_to_rotation_matrix.sv
sv/e2r_checker.sv
tb/euler_to_rotation_matrix_check.sv
tb/euler_to_rotation_matrix_test.sv
